// ----- rtl/core/plt_pkg.sv -----
// shared constants, types and helpers for the piecewise linear table interpolator
// no dependencies
`default_nettype none

package plt_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int PIU_W      = 7;
    localparam int PIDX_W     = 6;
    localparam int ENERGY_W   = 16;
    localparam int FLUX_W     = 24;
    localparam int STATUS_W   = 3;

    localparam logic [FLUX_W-1:0] FLUX_TOP = '1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INTERP     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BEYOND     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SAT        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO_WIDTH = 3'd4;

    localparam int FDIFF_W    = FLUX_W + 1;
    localparam int EDIFF_W    = ENERGY_W + 1;
    localparam int PROD_W     = FDIFF_W + EDIFF_W;
    localparam int DIVIDEND_W = FLUX_W + ENERGY_W;
    localparam int DIVISOR_W  = ENERGY_W;
    localparam int RADIX_BITS = 2;
    localparam int DIV_STEPS  = DIVIDEND_W / RADIX_BITS;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int SUM_W      = PROD_W + 1;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [CNT_W-1:0] active_count(input logic [PIU_W-1:0] piu);
        logic [CNT_W-1:0] res;
        if (32'(piu) > MAX_POINTS)
        begin
            res = CNT_W'(MAX_POINTS);
        end
        else
        begin
            res = CNT_W'(piu);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/piecewise_linear_table_interpolator.sv -----
// piecewise linear table interpolator: load beats write one breakpoint, query beats
// scan the table (one entry per cycle), multiply once and divide at two bits per cycle.
// a query's length is set by the points in use, the single table read port and the divider;
// one item at a time. a new item is taken while the previous result still waits at the
// output register.
// reset clears the sequencer, the output valid flag and points_in_use; the table is not cleared
`default_nettype none

module piecewise_linear_table_interpolator
    import plt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write_en,
    input  wire logic [PIU_W-1:0]    cfg_write_data,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire logic                command,
    input  wire logic [PIDX_W-1:0]   point_index,
    input  wire logic [ENERGY_W-1:0] point_energy,
    input  wire logic [FLUX_W-1:0]   point_flux,
    input  wire logic [ENERGY_W-1:0] query_energy,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output logic      [FLUX_W-1:0]   flux_value,
    output logic      [STATUS_W-1:0] status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_FIN,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [PIU_W-1:0]           piu_reg, piu_next;
    logic [CNT_W-1:0]           n_reg, n_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [CNT_W-1:0]           ridx_reg, ridx_next;
    logic                       dv_reg, dv_next;
    logic [ENERGY_W-1:0]        q_reg, q_next;
    logic [ENERGY_W-1:0]        prev_e_reg, prev_e_next;
    logic [FLUX_W-1:0]          prev_f_reg, prev_f_next;
    logic [FLUX_W-1:0]          f1_reg, f1_next;
    logic signed [FDIFF_W-1:0]  fd_reg, fd_next;
    logic signed [EDIFF_W-1:0]  ed_reg, ed_next;
    logic signed [EDIFF_W-1:0]  den_reg, den_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic                       neg_reg, neg_next;
    logic signed [PROD_W-1:0]   qs_reg, qs_next;
    logic [FLUX_W-1:0]          res_flux_reg, res_flux_next;
    logic [STATUS_W-1:0]        res_status_reg, res_status_next;
    logic                       result_valid_reg, result_valid_next;
    logic [FLUX_W-1:0]          flux_value_reg, flux_value_next;
    logic [STATUS_W-1:0]        status_reg, status_next;

    logic                       accept;
    logic                       tbl_wr_en;
    logic                       tbl_rd_en;
    logic [ENERGY_W-1:0]        rd_energy;
    logic [FLUX_W-1:0]          rd_flux;
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;
    assign tbl_wr_en  = accept && (command == CMD_LOAD) && (32'(point_index) < MAX_POINTS);
    assign tbl_rd_en  = (state_reg == S_SCAN) && (cnt_reg < n_reg);

    plt_table u_table (
        .clk       (clk),
        .wr_en     (tbl_wr_en),
        .wr_addr   (IDX_W'(point_index)),
        .wr_energy (point_energy),
        .wr_flux   (point_flux),
        .rd_en     (tbl_rd_en),
        .rd_addr   (cnt_reg[IDX_W-1:0]),
        .rd_energy (rd_energy),
        .rd_flux   (rd_flux)
    );

    always_comb
    begin
        logic signed [PROD_W-1:0] prod_abs;
        logic signed [EDIFF_W-1:0] den_abs;
        div_req.start    = (state_reg == S_DIV_GO);
        prod_abs         = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
        den_abs          = den_reg[EDIFF_W-1] ? -den_reg : den_reg;
        div_req.dividend = prod_abs[DIVIDEND_W-1:0];
        div_req.divisor  = den_abs[DIVISOR_W-1:0];
    end

    plt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        logic                     hit;
        logic                     last;
        logic                     out_take;
        logic signed [PROD_W-1:0] quot_s;
        logic signed [SUM_W-1:0]  sum;

        state_next        = state_reg;
        piu_next          = piu_reg;
        n_next            = n_reg;
        cnt_next          = cnt_reg;
        ridx_next         = cnt_reg;
        dv_next           = tbl_rd_en;
        q_next            = q_reg;
        prev_e_next       = prev_e_reg;
        prev_f_next       = prev_f_reg;
        f1_next           = f1_reg;
        fd_next           = fd_reg;
        ed_next           = ed_reg;
        den_next          = den_reg;
        prod_next         = prod_reg;
        neg_next          = neg_reg;
        qs_next           = qs_reg;
        res_flux_next     = res_flux_reg;
        res_status_next   = res_status_reg;
        flux_value_next   = flux_value_reg;
        status_next       = status_reg;

        hit      = dv_reg && (ridx_reg != '0) && (q_reg <= rd_energy);
        last     = dv_reg && (ridx_reg == n_reg - CNT_W'(1));
        out_take = result_valid_reg && !result_stall;
        quot_s   = $signed({{(PROD_W - DIVIDEND_W){1'b0}}, div_rsp.quotient});
        sum      = $signed({{(SUM_W - FLUX_W){1'b0}}, f1_reg}) + {qs_reg[PROD_W-1], qs_reg};
        result_valid_next = result_valid_reg && !out_take;

        if (cfg_write_en)
        begin
            piu_next = cfg_write_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (command == CMD_QUERY))
                begin
                    n_next   = active_count(piu_reg);
                    q_next   = query_energy;
                    cnt_next = '0;
                    if (active_count(piu_reg) == '0)
                    begin
                        res_flux_next   = '0;
                        res_status_next = ST_EMPTY;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (tbl_rd_en)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (hit)
                begin
                    f1_next  = prev_f_reg;
                    fd_next  = $signed({1'b0, rd_flux}) - $signed({1'b0, prev_f_reg});
                    ed_next  = $signed({1'b0, q_reg}) - $signed({1'b0, prev_e_reg});
                    den_next = $signed({1'b0, rd_energy}) - $signed({1'b0, prev_e_reg});
                    if (rd_energy == prev_e_reg)
                    begin
                        res_flux_next   = prev_f_reg;
                        res_status_next = ST_ZERO_WIDTH;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
                else if (last)
                begin
                    res_flux_next   = rd_flux;
                    res_status_next = ST_BEYOND;
                    state_next      = S_OUT;
                end
                else if (dv_reg)
                begin
                    prev_e_next = rd_energy;
                    prev_f_next = rd_flux;
                end
            end
            S_MUL:
            begin
                prod_next  = fd_reg * ed_reg;
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                neg_next   = prod_reg[PROD_W-1] ^ den_reg[EDIFF_W-1];
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    qs_next    = neg_reg ? -quot_s : quot_s;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (sum < 0)
                begin
                    res_flux_next   = '0;
                    res_status_next = ST_SAT;
                end
                else if (sum > $signed({{(SUM_W - FLUX_W){1'b0}}, FLUX_TOP}))
                begin
                    res_flux_next   = FLUX_TOP;
                    res_status_next = ST_SAT;
                end
                else
                begin
                    res_flux_next   = sum[FLUX_W-1:0];
                    res_status_next = ST_INTERP;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!result_valid_reg || out_take)
                begin
                    result_valid_next = 1'b1;
                    flux_value_next   = res_flux_reg;
                    status_next       = res_status_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            piu_reg          <= '0;
            n_reg            <= '0;
            cnt_reg          <= '0;
            ridx_reg         <= '0;
            dv_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            piu_reg          <= piu_next;
            n_reg            <= n_next;
            cnt_reg          <= cnt_next;
            ridx_reg         <= ridx_next;
            dv_reg           <= dv_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg          <= q_next;
        prev_e_reg     <= prev_e_next;
        prev_f_reg     <= prev_f_next;
        f1_reg         <= f1_next;
        fd_reg         <= fd_next;
        ed_reg         <= ed_next;
        den_reg        <= den_next;
        prod_reg       <= prod_next;
        neg_reg        <= neg_next;
        qs_reg         <= qs_next;
        res_flux_reg   <= res_flux_next;
        res_status_reg <= res_status_next;
        flux_value_reg <= flux_value_next;
        status_reg     <= status_next;
    end

    assign result_valid = result_valid_reg;
    assign flux_value   = flux_value_reg;
    assign status       = status_reg;

`ifndef SYNTHESIS
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (cnt_reg <= n_reg))
        else $error("scan counter ran past the points in use");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> (den_reg != '0))
        else $error("zero-width segment sent to divider");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !result_valid_reg) |=> (result_valid_reg && state_reg == S_IDLE))
        else $error("result not loaded into free output register");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/plt_table.sv -----
// breakpoint store: energy and flux memories, one write and one read port
// depends on plt_pkg
`default_nettype none

module plt_table
    import plt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                wr_en,
    input  wire logic [IDX_W-1:0]    wr_addr,
    input  wire logic [ENERGY_W-1:0] wr_energy,
    input  wire logic [FLUX_W-1:0]   wr_flux,
    input  wire logic                rd_en,
    input  wire logic [IDX_W-1:0]    rd_addr,
    output logic      [ENERGY_W-1:0] rd_energy,
    output logic      [FLUX_W-1:0]   rd_flux
);

    logic [ENERGY_W-1:0] energy_mem [MAX_POINTS];
    logic [FLUX_W-1:0]   flux_mem   [MAX_POINTS];
    logic [ENERGY_W-1:0] rd_energy_reg;
    logic [FLUX_W-1:0]   rd_flux_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            energy_mem[wr_addr] <= wr_energy;
            flux_mem[wr_addr]   <= wr_flux;
        end
        if (rd_en)
        begin
            rd_energy_reg <= energy_mem[rd_addr];
            rd_flux_reg   <= flux_mem[rd_addr];
        end
    end

    assign rd_energy = rd_energy_reg;
    assign rd_flux   = rd_flux_reg;

endmodule

`default_nettype wire

// ----- rtl/core/plt_div.sv -----
// unsigned restoring divider, two quotient bits per cycle
// depends on plt_pkg
`default_nettype none

module plt_div
    import plt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [DIVIDEND_W-1:0] num_reg, num_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  den_reg;
    logic [STEP_W-1:0]     cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    always_comb
    begin
        logic [DIVISOR_W:0] trial;
        num_next = num_reg;
        rem_next = rem_reg;
        for (int k = 0; k < RADIX_BITS; k++)
        begin
            trial    = {rem_next, num_next[DIVIDEND_W-1]};
            num_next = {num_next[DIVIDEND_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next    = DIVISOR_W'(trial - {1'b0, den_reg});
                num_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.dividend;
            rem_reg <= '0;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = num_reg;

endmodule

`default_nettype wire

// ----- verif/tb_piecewise_linear_table_interpolator.sv -----
`timescale 1ns / 1ps
// testbench for piecewise_linear_table_interpolator: loads breakpoint tables, queries flux,
// and checks every result beat against a scoreboard that predicts the interpolation
// depends on plt_pkg and the piecewise_linear_table_interpolator rtl

module tb_piecewise_linear_table_interpolator;
    import plt_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TARGET_ITEMS = 1400;

    typedef struct packed {
        logic [FLUX_W-1:0]   flux;
        logic [STATUS_W-1:0] status;
    } flux_answer_t;

    class flux_scoreboard;
        logic [ENERGY_W-1:0] energy_tab [MAX_POINTS];
        logic [FLUX_W-1:0]   flux_tab [MAX_POINTS];
        logic [PIU_W-1:0]    points = '0;
        flux_answer_t        awaited [$];
        int                  errors = 0;
        int                  loads = 0;
        int                  queries = 0;
        int                  results_seen = 0;
        int                  status_hits [5] = '{0, 0, 0, 0, 0};

        function void note_item(input logic cmd, input logic [PIDX_W-1:0] idx,
                                 input logic [ENERGY_W-1:0] e, input logic [FLUX_W-1:0] f,
                                 input logic [ENERGY_W-1:0] q);
            int           n;
            int           k;
            bit           hit;
            longint       e1, e2, f1, f2, span, qv, v, top;
            flux_answer_t a;
            if (cmd == CMD_LOAD)
            begin
                energy_tab[idx] = e;
                flux_tab[idx]   = f;
                loads++;
            end
            else
            begin
                queries++;
                n   = (int'(points) > MAX_POINTS) ? MAX_POINTS : int'(points);
                hit = 1'b0;
                top = FLUX_TOP;
                qv  = q;
                if (n == 0)
                begin
                    a.flux   = '0;
                    a.status = ST_EMPTY;
                end
                else
                begin
                    a.flux   = flux_tab[n-1];
                    a.status = ST_BEYOND;
                    for (k = 1; k < n; k++)
                    begin
                        if (!hit && q <= energy_tab[k])
                        begin
                            hit  = 1'b1;
                            e1   = energy_tab[k-1];
                            e2   = energy_tab[k];
                            f1   = flux_tab[k-1];
                            f2   = flux_tab[k];
                            span = e2 - e1;
                            if (span == 0)
                            begin
                                a.flux   = flux_tab[k-1];
                                a.status = ST_ZERO_WIDTH;
                            end
                            else
                            begin
                                v = f1 + ((f2 - f1) * (qv - e1)) / span;
                                if (v < 0)
                                begin
                                    a.flux   = '0;
                                    a.status = ST_SAT;
                                end
                                else if (v > top)
                                begin
                                    a.flux   = FLUX_TOP;
                                    a.status = ST_SAT;
                                end
                                else
                                begin
                                    a.flux   = v[FLUX_W-1:0];
                                    a.status = ST_INTERP;
                                end
                            end
                        end
                    end
                end
                status_hits[a.status]++;
                awaited.push_back(a);
            end
        endfunction

        function void check_result(input logic [FLUX_W-1:0] flux,
                                   input logic [STATUS_W-1:0] st);
            flux_answer_t a;
            results_seen++;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, actual flux %0d status %0d",
                         $time, flux, st);
            end
            else
            begin
                a = awaited.pop_front();
                if (flux !== a.flux)
                begin
                    errors++;
                    $display("%0t: flux_value mismatch, expected %0d actual %0d",
                             $time, a.flux, flux);
                end
                if (st !== a.status)
                begin
                    errors++;
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, a.status, st);
                end
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write_en = 1'b0;
    logic [PIU_W-1:0]    cfg_write_data = '0;
    logic                item_valid = 1'b0;
    logic                item_stall;
    logic                command = CMD_LOAD;
    logic [PIDX_W-1:0]   point_index = '0;
    logic [ENERGY_W-1:0] point_energy = '0;
    logic [FLUX_W-1:0]   point_flux = '0;
    logic [ENERGY_W-1:0] query_energy = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [FLUX_W-1:0]   flux_value;
    logic [STATUS_W-1:0] status;

    flux_scoreboard sb;
    int             items_sent = 0;
    int             settings_used = 0;
    int             cycle_count = 0;
    int             hold_left = 0;
    bit             hold_done = 1'b0;
    bit             gaps_on = 1'b1;

    piecewise_linear_table_interpolator u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .command        (command),
        .point_index    (point_index),
        .point_energy   (point_energy),
        .point_flux     (point_flux),
        .query_energy   (query_energy),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .flux_value     (flux_value),
        .status         (status)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_piecewise_linear_table_interpolator: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            sb.check_result(flux_value, status);
        end
    end

    // result side: random stalls plus one long hold-off so the block backs up
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (!hold_done && sb.results_seen >= 300)
        begin
            hold_done = 1'b1;
            hold_left = 600;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= gaps_on && ($urandom_range(0, 99) < 23);
        end
    end

    // entered and left at a falling edge; valid stays high between back-to-back beats
    task automatic offer(input logic cmd, input logic [PIDX_W-1:0] idx,
                         input logic [ENERGY_W-1:0] e, input logic [FLUX_W-1:0] f,
                         input logic [ENERGY_W-1:0] q);
        gaps_on = (items_sent < 500) || (items_sent >= 700);
        while (gaps_on && $urandom_range(0, 99) < 23)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid   <= 1'b1;
        command      <= cmd;
        point_index  <= idx;
        point_energy <= e;
        point_flux   <= f;
        query_energy <= q;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        sb.note_item(cmd, idx, e, f, q);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic set_points(input logic [PIU_W-1:0] val);
        item_valid <= 1'b0;
        while (sb.awaited.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= val;
        @(posedge clk);
        sb.points = val;
        settings_used++;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    function automatic logic [FLUX_W-1:0] pick_flux();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return FLUX_TOP;
            default: return FLUX_W'($urandom());
        endcase
    endfunction

    function automatic logic [ENERGY_W-1:0] pick_query(input int n);
        int e;
        e = (n > 0) ? int'(sb.energy_tab[$urandom_range(0, n - 1)]) : $urandom_range(0, 65535);
        case ($urandom_range(0, 9))
            0: e = 0;
            1: e = 65535;
            2, 3: e = e;
            4, 5, 6: e = e + int'($urandom_range(0, 6)) - 3;
            default: e = $urandom_range(0, 65535);
        endcase
        if (e < 0)
        begin
            e = 0;
        end
        if (e > 65535)
        begin
            e = 65535;
        end
        return ENERGY_W'(e);
    endfunction

    // mostly ascending tables, some with repeated energies, some in no order at all
    task automatic fill_table(input int n);
        int shape;
        int stride;
        int k;
        int e;
        shape  = $urandom_range(0, 9);
        stride = (n > 0) ? 65535 / n : 65535;
        e      = $urandom_range(0, stride);
        for (k = 0; k < n; k++)
        begin
            if (shape >= 8)
            begin
                e = $urandom_range(0, 65535);
            end
            else if (k > 0 && !(shape == 7 && $urandom_range(0, 2) == 0))
            begin
                e = e + int'($urandom_range(1, stride));
            end
            if (e > 65535)
            begin
                e = 65535;
            end
            offer(CMD_LOAD, PIDX_W'(k), ENERGY_W'(e), pick_flux(), ENERGY_W'($urandom()));
        end
    endtask

    initial
    begin
        int               phase;
        int               p;
        int               n;
        int               j;
        int               nq;
        logic [PIU_W-1:0] piu;
        sb = new();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table, single point, zero-width, beyond, saturation both ways, descending
        set_points(PIU_W'(0));
        offer(CMD_QUERY, '0, '0, '0, '0);
        offer(CMD_QUERY, '1, '1, FLUX_TOP, '1);
        offer(CMD_LOAD, PIDX_W'(0), ENERGY_W'(1000), FLUX_W'(5000), '1);
        offer(CMD_LOAD, PIDX_W'(1), ENERGY_W'(1000), FLUX_W'(7), '0);
        offer(CMD_LOAD, PIDX_W'(2), ENERGY_W'(3000), FLUX_TOP, '0);
        offer(CMD_LOAD, PIDX_W'(3), '1, '0, '0);
        set_points(PIU_W'(1));
        offer(CMD_QUERY, '0, '0, '0, ENERGY_W'(500));
        set_points(PIU_W'(4));
        offer(CMD_QUERY, '0, '0, '0, '0);
        offer(CMD_QUERY, '0, '0, '0, ENERGY_W'(2000));
        offer(CMD_QUERY, '0, '0, '0, ENERGY_W'(3000));
        offer(CMD_QUERY, '0, '0, '0, '1);
        set_points(PIU_W'(3));
        offer(CMD_QUERY, '0, '0, '0, '1);
        offer(CMD_LOAD, PIDX_W'(0), ENERGY_W'(1000), FLUX_TOP, '0);
        offer(CMD_LOAD, PIDX_W'(1), ENERGY_W'(1001), '0, '0);
        offer(CMD_QUERY, '0, '0, '0, '0);
        offer(CMD_LOAD, PIDX_W'(0), ENERGY_W'(1000), '0, '0);
        offer(CMD_LOAD, PIDX_W'(1), ENERGY_W'(1001), FLUX_TOP, '0);
        offer(CMD_QUERY, '0, '0, '0, '0);
        offer(CMD_LOAD, PIDX_W'(1), ENERGY_W'(500), FLUX_TOP, '0);
        offer(CMD_QUERY, '0, '0, '0, ENERGY_W'(400));

        phase = 0;
        while (items_sent < TARGET_ITEMS)
        begin
            if (phase == 1)
            begin
                p = 127;
            end
            else if (phase == 3)
            begin
                p = 64;
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0: p = 0;
                    1: p = 1;
                    2: p = 64;
                    3: p = $urandom_range(65, 127);
                    4, 5, 6: p = $urandom_range(13, 63);
                    default: p = $urandom_range(2, 12);
                endcase
            end
            n = (p > MAX_POINTS) ? MAX_POINTS : p;
            piu = PIU_W'(p);
            fill_table(n);
            set_points(piu);
            nq = $urandom_range(15, 45);
            for (j = 0; j < nq; j++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    offer(CMD_LOAD, PIDX_W'($urandom()), ENERGY_W'($urandom()), pick_flux(),
                          ENERGY_W'($urandom()));
                end
                else
                begin
                    offer(CMD_QUERY, PIDX_W'($urandom()), ENERGY_W'($urandom()),
                          FLUX_W'($urandom()), pick_query(n));
                end
            end
            phase++;
        end

        item_valid <= 1'b0;
        while (sb.awaited.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (120) @(negedge clk);

        $display("run covered %0d loads and %0d queries over %0d table sizes",
                 sb.loads, sb.queries, settings_used);
        $display("status mix interp/beyond/saturated/empty/zero-width: %0d/%0d/%0d/%0d/%0d",
                 sb.status_hits[0], sb.status_hits[1], sb.status_hits[2],
                 sb.status_hits[3], sb.status_hits[4]);
        if (sb.errors == 0 && sb.awaited.size() == 0)
        begin
            $display("tb_piecewise_linear_table_interpolator: clean");
        end
        else
        begin
            $display("tb_piecewise_linear_table_interpolator: errors");
        end
        $finish;
    end

endmodule
